>>> sv/s2i_pkg.sv
// Shared types and constants of the SPI to I2C bridge.
// No dependencies; every other file of the bridge except s2i_ram imports this package.
package s2i_pkg;

  // Command bytes that open an SPI frame.
  localparam logic [7:0] CMD_WR_N   = 8'h00;
  localparam logic [7:0] CMD_RD_N   = 8'h01;
  localparam logic [7:0] CMD_WR_RD  = 8'h02;
  localparam logic [7:0] CMD_WR_WR  = 8'h03;
  localparam logic [7:0] CMD_RD_BUF = 8'h06;
  localparam logic [7:0] CMD_CONF   = 8'h18;
  localparam logic [7:0] CMD_WR_REG = 8'h20;
  localparam logic [7:0] CMD_RD_REG = 8'h21;
  localparam logic [7:0] CMD_PWR    = 8'h30;
  localparam logic [7:0] CMD_NONE   = 8'hff;

  // Filler response byte.
  localparam logic [7:0] RESP_IDLE  = 8'hff;

  typedef enum logic [1:0] {
    OP_SPI    = 2'd0,
    OP_SEL    = 2'd1,
    OP_I2C    = 2'd2,
    OP_IGNORE = 2'd3
  } s2i_op_e;

  typedef enum logic [2:0] {
    KIND_SPI   = 3'd0,
    KIND_START = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_READ  = 3'd3,
    KIND_STOP  = 3'd4
  } s2i_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SPI_RESP,
    ST_REL_LEN,
    ST_REL_ADDR,
    ST_START,
    ST_BODY,
    ST_STOP
  } s2i_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      spi_skip;
    logic      spi_exec;
    logic      sel_low;
    logic      sel_high;
    logic      len_load;
    logic      addr_load;
    logic      rx_write;
    logic      out_load;
    s2i_kind_e out_kind;
    logic      out_last;
  } s2i_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    s2i_op_e op;
    logic    level;
    logic    released;
    logic    burst_cmd;
    logic    rd_cmd;
    logic    cnt_zero;
    logic    cnt_one;
    logic    out_free;
  } s2i_stat_t;

endpackage

>>> sv/s2i_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the transmit and receive stores.
module s2i_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds until the next read.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/s2i_ctrl.sv
// Controller state machine of the SPI to I2C bridge.
// Depends on s2i_pkg; drives the datapath through s2i_cmd_t.
module s2i_ctrl
  import s2i_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  s2i_stat_t stat_i,
  output s2i_cmd_t  cmd_o
);

  s2i_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_kind = KIND_SPI;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        unique case (stat_i.op)
          OP_SPI: begin
            if (stat_i.released) begin
              cmd_o.spi_skip = 1'b1;
            end else begin
              cmd_o.spi_exec = 1'b1;
              state_d        = ST_SPI_RESP;
            end
          end
          OP_SEL: begin
            if (!stat_i.level) begin
              cmd_o.sel_low = 1'b1;
            end else begin
              cmd_o.sel_high = 1'b1;
              if (stat_i.burst_cmd) begin
                state_d = ST_REL_LEN;
              end
            end
          end
          OP_I2C: begin
            cmd_o.rx_write = 1'b1;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SPI_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_SPI;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_REL_LEN: begin
        cmd_o.len_load = 1'b1;
        state_d        = ST_REL_ADDR;
      end
      ST_REL_ADDR: begin
        cmd_o.addr_load = 1'b1;
        state_d         = ST_START;
      end
      ST_START: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_START;
          state_d        = stat_i.cnt_zero ? ST_STOP : ST_BODY;
        end
      end
      ST_BODY: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = stat_i.rd_cmd ? KIND_READ : KIND_WRITE;
          if (stat_i.cnt_one) begin
            state_d = ST_STOP;
          end
        end
      end
      ST_STOP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_STOP;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The byte loop is only entered with bytes left to send.
  a_body_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BODY |-> !stat_i.cnt_zero)
    else $error("byte loop entered with zero count");

  // The final result of an item returns the controller to idle.
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load && cmd_o.out_last |=> state_q == ST_IDLE)
    else $error("last result did not end the transaction");

  // A burst only starts from a release with a write-n or read-n command.
  a_burst_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REL_LEN |-> $past(state_q) == ST_DECODE && $past(stat_i.burst_cmd))
    else $error("release burst without a burst command");

endmodule

>>> sv/s2i_dp.sv
// Datapath of the SPI to I2C bridge: frame state, stores, registers and output register.
// Depends on s2i_pkg and s2i_ram; controlled by s2i_ctrl.
module s2i_dp
  import s2i_pkg::*;
#(
  parameter int BUF_DEPTH = 64,
  parameter int REG_COUNT = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  s2i_cmd_t   cmd_i,
  output s2i_stat_t  stat_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] spi_byte_i,
  input  logic       select_level_i,
  input  logic [7:0] i2c_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] slave_address_o,
  output logic       last_o
);

  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int PW  = $clog2(BUF_DEPTH + 1);
  localparam int RPW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [7:0] DepthB    = 8'(BUF_DEPTH);
  localparam logic [7:0] LenMaxB   = 8'(BUF_DEPTH - 3);
  localparam logic [7:0] RegCountB = 8'(REG_COUNT);

  // Captured input item.
  s2i_op_e    op_q;
  logic [7:0] spi_q;
  logic       lvl_q;
  logic [7:0] i2c_q;

  // Frame and bridge state.
  logic           released_q;
  logic [7:0]     step_q;
  logic [7:0]     cmd_q;
  logic [RPW-1:0] reg_ptr_q;
  logic [7:0]     regs_q [REG_COUNT];
  logic [PW-1:0]  rxp_q;

  // Response and burst working registers.
  logic [7:0]    resp_q, resp_d;
  logic          use_rx_q;
  logic [AW-1:0] cnt_q;
  logic [7:0]    addr_q;
  logic [AW-1:0] rd_ptr_q;

  // Output register.
  logic       out_valid_q;
  s2i_kind_e  kind_q;
  logic [7:0] data_q;
  logic [7:0] saddr_q;
  logic       last_q;

  logic [7:0]    cmd_eff;
  logic          is_frame, is_rdbuf, is_reg;
  logic          tx_we, tx_re, rx_we, rx_re;
  logic [AW-1:0] tx_raddr, rx_raddr;
  logic [7:0]    tx_rdata, rx_rdata;
  logic [AW-1:0] len_sat;
  logic          out_free;
  logic          burst_cmd;
  logic          body_load;
  logic [7:0]    out_data, out_saddr;

  assign cmd_eff   = (step_q == 8'd0) ? spi_q : cmd_q;
  assign burst_cmd = (cmd_q == CMD_WR_N) || (cmd_q == CMD_RD_N);
  assign out_free  = !out_valid_q || out_ready_i;
  assign body_load = cmd_i.out_load &&
                     (cmd_i.out_kind == KIND_WRITE || cmd_i.out_kind == KIND_READ);

  always_comb begin
    is_frame = 1'b0;
    is_rdbuf = 1'b0;
    is_reg   = 1'b0;
    unique case (cmd_eff) inside
      CMD_WR_N, CMD_RD_N, CMD_WR_RD, CMD_WR_WR: is_frame = 1'b1;
      CMD_RD_BUF:                               is_rdbuf = 1'b1;
      CMD_WR_REG, CMD_RD_REG:                   is_reg   = 1'b1;
      default: begin
        is_frame = 1'b0;
      end
    endcase
  end

  // SPI byte side: store writes, receive store reads and the response byte.
  assign tx_we    = cmd_i.spi_exec && is_frame && (step_q < DepthB);
  assign rx_re    = cmd_i.spi_exec && is_rdbuf && (step_q != 8'd0) && (step_q <= DepthB);
  assign rx_raddr = AW'(step_q - 8'd1);
  assign rx_we    = cmd_i.rx_write && (cmd_q == CMD_RD_N) && (rxp_q < PW'(BUF_DEPTH));

  always_comb begin
    resp_d = RESP_IDLE;
    if (is_reg && step_q == 8'd2 && cmd_eff == CMD_RD_REG) begin
      resp_d = regs_q[reg_ptr_q];
    end
  end

  // Transmit store read port: length, address, then one data byte per result.
  always_comb begin
    tx_re    = 1'b0;
    tx_raddr = rd_ptr_q;
    if (cmd_i.sel_high && burst_cmd) begin
      tx_re    = 1'b1;
      tx_raddr = AW'(1);
    end else if (cmd_i.len_load) begin
      tx_re    = 1'b1;
      tx_raddr = AW'(2);
    end else if (cmd_i.addr_load) begin
      tx_re    = 1'b1;
      tx_raddr = AW'(3);
    end else if (body_load) begin
      tx_re    = 1'b1;
      tx_raddr = rd_ptr_q;
    end
  end

  assign len_sat = (tx_rdata > LenMaxB) ? LenMaxB[AW-1:0] : tx_rdata[AW-1:0];

  s2i_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (step_q[AW-1:0]),
    .wdata_i (spi_q),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  s2i_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rxp_q[AW-1:0]),
    .wdata_i (i2c_q),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  always_comb begin
    out_data  = 8'd0;
    out_saddr = addr_q;
    case (cmd_i.out_kind)
      KIND_SPI: begin
        out_data  = use_rx_q ? rx_rdata : resp_q;
        out_saddr = 8'd0;
      end
      KIND_WRITE: out_data = tx_rdata;
      default:    out_data = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      released_q  <= 1'b0;
      step_q      <= 8'd0;
      cmd_q       <= CMD_WR_N;
      reg_ptr_q   <= '0;
      rxp_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= 8'd0;
      end
    end else begin
      if (cmd_i.spi_skip) begin
        step_q <= 8'd0;
      end
      if (cmd_i.spi_exec) begin
        if (step_q == 8'd0) begin
          cmd_q <= spi_q;
        end
        if (step_q != 8'hff) begin
          step_q <= step_q + 8'd1;
        end
        if (is_reg && step_q == 8'd1 && spi_q < RegCountB) begin
          reg_ptr_q <= spi_q[RPW-1:0];
        end
        if (is_reg && step_q == 8'd2 && cmd_eff == CMD_WR_REG) begin
          regs_q[reg_ptr_q] <= spi_q;
        end
      end
      if (cmd_i.sel_low) begin
        released_q <= 1'b0;
        step_q     <= 8'd0;
        cmd_q      <= CMD_NONE;
      end
      if (cmd_i.sel_high) begin
        released_q <= 1'b1;
        step_q     <= 8'd0;
        if (cmd_q == CMD_RD_N) begin
          rxp_q <= '0;
        end
      end
      if (rx_we) begin
        rxp_q <= rxp_q + PW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= s2i_op_e'(operation_i);
      spi_q <= spi_byte_i;
      lvl_q <= select_level_i;
      i2c_q <= i2c_byte_i;
    end
    if (cmd_i.spi_exec) begin
      resp_q   <= resp_d;
      use_rx_q <= rx_re;
    end
    if (cmd_i.len_load) begin
      cnt_q <= len_sat;
    end else if (body_load) begin
      cnt_q <= cnt_q - AW'(1);
    end
    if (cmd_i.addr_load) begin
      addr_q   <= tx_rdata;
      rd_ptr_q <= AW'(4);
    end else if (body_load) begin
      rd_ptr_q <= rd_ptr_q + AW'(1);
    end
    if (cmd_i.out_load) begin
      kind_q  <= cmd_i.out_kind;
      data_q  <= out_data;
      saddr_q <= out_saddr;
      last_q  <= cmd_i.out_last;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.level     = lvl_q;
  assign stat_o.released  = released_q;
  assign stat_o.burst_cmd = burst_cmd;
  assign stat_o.rd_cmd    = (cmd_q == CMD_RD_N);
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.cnt_one   = (cnt_q == AW'(1));
  assign stat_o.out_free  = out_free;

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign slave_address_o = saddr_q;
  assign last_o          = last_q;

  // The receive pointer saturates at the store depth.
  a_rxp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rxp_q <= PW'(BUF_DEPTH))
    else $error("receive pointer past store depth");

  // A result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output register overwritten");

  // Frame bytes are only stored while selected.
  a_tx_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_we |-> !released_q)
    else $error("transmit store written while released");

endmodule

>>> sv/spi_to_i2c_bridge_top.sv
// SPI to I2C bridge. One transaction at a time: an SPI byte while selected gets one
// response. A release burst shows START, then one result per cycle while the output
// register is free (len + 2 results in all), paced by the single read port of the
// transmit store. Input is taken again once the last result sits in the output
// register. Reset clears control state, the frame state and the internal registers;
// the transmit and receive stores are not cleared.
//
// Depends on s2i_pkg, s2i_ctrl, s2i_dp and s2i_ram.
module spi_to_i2c_bridge_top
  import s2i_pkg::*;
#(
  parameter int BUF_DEPTH = 64,
  parameter int REG_COUNT = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input channel: one transaction per SPI byte, select change or I2C read byte.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] spi_byte_i,
  input  logic       select_level_i,
  input  logic [7:0] i2c_byte_i,
  // Output channel: SPI responses and I2C bus operations.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] slave_address_o,
  output logic       last_o
);

  s2i_cmd_t  cmd;
  s2i_stat_t stat;

  // The controller sequences each transaction; it is ready only when idle, but the
  // output register lets a new transaction start while a result still waits.
  s2i_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds frame state, both byte stores, the internal registers and the
  // output register.
  s2i_dp #(
    .BUF_DEPTH (BUF_DEPTH),
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .spi_byte_i      (spi_byte_i),
    .select_level_i  (select_level_i),
    .i2c_byte_i      (i2c_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .slave_address_o (slave_address_o),
    .last_o          (last_o)
  );

endmodule

>>> tb/tb_spi_to_i2c_bridge_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for spi_to_i2c_bridge_top: directed table, then random SPI frames.
// Depends on s2i_pkg and the bridge RTL; results are checked against a built-in predictor.
module tb_spi_to_i2c_bridge_top;
  import s2i_pkg::*;

  localparam int BUF_DEPTH = 64;
  localparam int REG_COUNT = 6;
  // Longest payload of one release burst.
  localparam int MAX_LEN   = BUF_DEPTH - 3;

  // One expected output transaction of the bridge.
  typedef struct packed {
    s2i_kind_e  kind;
    logic [7:0] data;
    logic [7:0] addr;
    logic       last;
  } bridge_res_t;

  // One row of the directed table. Where typed is set, the row causes a single
  // SPI response whose byte is given by data.
  typedef struct {
    s2i_op_e    op;
    logic [7:0] sb;
    logic       lvl;
    logic [7:0] ib;
    bit         typed;
    logic [7:0] data;
  } dir_row_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [1:0] operation_i    = 2'd0;
  logic [7:0] spi_byte_i     = 8'h00;
  logic       select_level_i = 1'b0;
  logic [7:0] i2c_byte_i     = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [2:0] kind_o;
  logic [7:0] data_byte_o;
  logic [7:0] slave_address_o;
  logic       last_o;

  spi_to_i2c_bridge_top #(
    .BUF_DEPTH(BUF_DEPTH),
    .REG_COUNT(REG_COUNT)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .spi_byte_i     (spi_byte_i),
    .select_level_i (select_level_i),
    .i2c_byte_i     (i2c_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .slave_address_o(slave_address_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state. The written flags track which store entries hold data,
  // so that the stimulus never makes the bridge read an entry that was never
  // written.
  logic       m_released;
  logic [7:0] m_step;
  logic [7:0] m_cmd;
  logic [7:0] m_tx [BUF_DEPTH];
  logic [7:0] m_rx [BUF_DEPTH];
  bit         m_tx_wr [BUF_DEPTH];
  bit         m_rx_wr [BUF_DEPTH];
  logic [7:0] m_regs [REG_COUNT];
  logic [2:0] m_reg_ptr;
  logic [6:0] m_rx_ptr;

  // Results of the transaction just predicted, and every result still due.
  bridge_res_t pred_q[$];
  bridge_res_t awaited_q[$];

  int send_idle_pct = 26;
  int recv_idle_pct = 70;
  int item_count    = 0;
  int fail_count    = 0;

  // Directed part. It opens right after reset, where the bridge counts as
  // selected and the first byte is taken as a command.
  dir_row_t dir_rows [28] = '{
    // Register write to the highest register.
    '{OP_SPI, CMD_WR_REG, 1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'h05,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'ha5,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SEL, 8'hff,      1'b0, 8'hff, 1'b0, 8'h00},
    // Register read; the out-of-range offset leaves the pointer on register 5.
    '{OP_SPI, CMD_RD_REG, 1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'h06,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'h00,      1'b0, 8'h00, 1'b1, 8'ha5},
    '{OP_SEL, 8'h00,      1'b0, 8'h00, 1'b0, 8'h00},
    // Write-n frame with two data bytes at the extremes.
    '{OP_SPI, CMD_WR_N,   1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'h02,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'h50,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'h00,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'hff,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SEL, 8'h00,      1'b1, 8'h00, 1'b0, 8'h00},
    // A second release while released replays the stored frame.
    '{OP_SEL, 8'hff,      1'b1, 8'hff, 1'b0, 8'h00},
    // Bytes while released and the unused operation leave no trace.
    '{OP_SPI, 8'h3c,      1'b0, 8'h00, 1'b0, 8'h00},
    '{OP_IGNORE, 8'hff,   1'b1, 8'hff, 1'b0, 8'h00},
    // Read-n whose length saturates, giving the longest burst.
    '{OP_SEL, 8'h00,      1'b0, 8'h00, 1'b0, 8'h00},
    '{OP_SPI, CMD_RD_N,   1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'hff,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'ha1,      1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SEL, 8'h00,      1'b1, 8'h00, 1'b0, 8'h00},
    '{OP_I2C, 8'h00,      1'b0, 8'h00, 1'b0, 8'h00},
    '{OP_I2C, 8'hff,      1'b0, 8'hff, 1'b0, 8'h00},
    // Read the two received bytes back.
    '{OP_SEL, 8'h00,      1'b0, 8'h00, 1'b0, 8'h00},
    '{OP_SPI, CMD_RD_BUF, 1'b0, 8'h00, 1'b1, RESP_IDLE},
    '{OP_SPI, 8'h5a,      1'b0, 8'h00, 1'b1, 8'h00},
    '{OP_SPI, 8'hc3,      1'b0, 8'h00, 1'b1, 8'hff}
  };

  function automatic void clear_model();
    m_released = 1'b0;
    m_step     = 8'h00;
    m_cmd      = CMD_WR_N;
    m_reg_ptr  = 3'd0;
    m_rx_ptr   = 7'd0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      m_tx_wr[i] = 1'b0;
      m_rx_wr[i] = 1'b0;
    end
    for (int i = 0; i < REG_COUNT; i++) m_regs[i] = 8'h00;
  endfunction

  function automatic void push_result(s2i_kind_e kind, logic [7:0] data, logic [7:0] addr,
                                      logic last);
    bridge_res_t r;
    r.kind = kind;
    r.data = data;
    r.addr = addr;
    r.last = last;
    pred_q.push_back(r);
  endfunction

  // Advances the predictor by one input transaction and leaves its results in pred_q.
  function automatic void compute_responses(s2i_op_e op, logic [7:0] sb, logic lvl,
                                            logic [7:0] ib);
    logic [7:0]  resp;
    logic [7:0]  cur;
    logic [7:0]  addr;
    int unsigned len;
    bit          rd;
    pred_q.delete();
    case (op)
      OP_SPI: begin
        if (m_released) begin
          m_step = 8'h00;
        end else begin
          resp = RESP_IDLE;
          cur  = m_step;
          if (cur == 8'h00) m_cmd = sb;
          case (m_cmd)
            CMD_WR_N, CMD_RD_N, CMD_WR_RD, CMD_WR_WR: begin
              if (cur < BUF_DEPTH) begin
                m_tx[cur]    = sb;
                m_tx_wr[cur] = 1'b1;
              end
            end
            CMD_RD_BUF: begin
              if (cur >= 1 && cur <= BUF_DEPTH) resp = m_rx[cur - 1];
            end
            CMD_WR_REG, CMD_RD_REG: begin
              if (cur == 8'd1) begin
                if (sb < REG_COUNT) m_reg_ptr = sb[2:0];
              end else if (cur == 8'd2 && m_reg_ptr < REG_COUNT) begin
                if (m_cmd == CMD_WR_REG) m_regs[m_reg_ptr] = sb;
                else resp = m_regs[m_reg_ptr];
              end
            end
            default: ;
          endcase
          if (m_step != 8'hff) m_step = m_step + 8'd1;
          push_result(KIND_SPI, resp, 8'h00, 1'b1);
        end
      end
      OP_SEL: begin
        m_released = lvl;
        m_step     = 8'h00;
        if (!lvl) begin
          m_cmd = CMD_NONE;
        end else if (m_cmd == CMD_WR_N || m_cmd == CMD_RD_N) begin
          rd   = (m_cmd == CMD_RD_N);
          len  = m_tx[1];
          if (len > MAX_LEN) len = MAX_LEN;
          addr = m_tx[2];
          if (rd) m_rx_ptr = 7'd0;
          push_result(KIND_START, 8'h00, addr, 1'b0);
          for (int i = 0; i < len; i++) begin
            if (rd) push_result(KIND_READ, 8'h00, addr, 1'b0);
            else push_result(KIND_WRITE, m_tx[3 + i], addr, 1'b0);
          end
          push_result(KIND_STOP, 8'h00, addr, 1'b1);
        end
      end
      OP_I2C: begin
        if (m_cmd == CMD_RD_N && m_rx_ptr < BUF_DEPTH) begin
          m_rx[m_rx_ptr]    = ib;
          m_rx_wr[m_rx_ptr] = 1'b1;
          m_rx_ptr          = m_rx_ptr + 7'd1;
        end
      end
      default: ;
    endcase
  endfunction

  // False where the transaction would make the bridge read a store entry that
  // was never written: a read-buffer step on an empty receive entry, or a
  // release whose length, address or write data were never stored.
  function automatic bit reads_only_written(s2i_op_e op, logic [7:0] sb, logic lvl);
    logic [7:0]  c;
    int unsigned len;
    reads_only_written = 1'b1;
    if (op == OP_SPI && !m_released) begin
      c = (m_step == 8'h00) ? sb : m_cmd;
      if (c == CMD_RD_BUF && m_step >= 1 && m_step <= BUF_DEPTH && !m_rx_wr[m_step - 1])
        reads_only_written = 1'b0;
    end else if (op == OP_SEL && lvl && (m_cmd == CMD_WR_N || m_cmd == CMD_RD_N)) begin
      if (!m_tx_wr[1] || !m_tx_wr[2]) begin
        reads_only_written = 1'b0;
      end else if (m_cmd == CMD_WR_N) begin
        len = m_tx[1];
        if (len > MAX_LEN) len = MAX_LEN;
        for (int i = 0; i < len; i++) if (!m_tx_wr[3 + i]) reads_only_written = 1'b0;
      end
    end
  endfunction

  // Number of receive entries written in a row from the first one.
  function automatic int rx_filled();
    int k;
    k = 0;
    while (k < BUF_DEPTH && m_rx_wr[k]) k++;
    return k;
  endfunction

  // Sends one transaction. It is entered at a rising edge, and it returns at
  // the edge where the bridge accepted the transaction, with valid still high.
  // An unsafe transaction is turned into a select, which is always harmless.
  task automatic send_item(s2i_op_e op, logic [7:0] sb, logic lvl, logic [7:0] ib,
                           bit typed = 1'b0, logic [7:0] typed_data = 8'h00);
    int unsigned gap;
    bridge_res_t r;
    if (!reads_only_written(op, sb, lvl)) begin
      op  = OP_SEL;
      lvl = 1'b0;
    end
    // Only transactions that do something count toward the random budget.
    if (op != OP_IGNORE && !(op == OP_SPI && m_released) &&
        !(op == OP_I2C && (m_cmd != CMD_RD_N || m_rx_ptr >= BUF_DEPTH)))
      item_count++;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    spi_byte_i     <= sb;
    select_level_i <= lvl;
    i2c_byte_i     <= ib;
    compute_responses(op, sb, lvl, ib);
    if (typed) begin
      // The table value stands in for the prediction on these rows.
      r.kind = KIND_SPI;
      r.data = typed_data;
      r.addr = 8'h00;
      r.last = 1'b1;
      awaited_q.push_back(r);
    end else begin
      foreach (pred_q[i]) awaited_q.push_back(pred_q[i]);
    end
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // The sender holds off until every awaited result has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_q.size() != 0);
  endtask

  function automatic int unsigned pick_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(0, 6);
    if (p < 95) return $urandom_range(7, 20);
    return $urandom_range(MAX_LEN, 255);
  endfunction

  task automatic spi(logic [7:0] b);
    send_item(OP_SPI, b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic select_pin(logic lvl);
    send_item(OP_SEL, 8'($urandom_range(0, 255)), lvl, 8'($urandom_range(0, 255)));
  endtask

  // One random SPI frame. Most frames are well formed with random content;
  // some are cut short, overrun the store or are plain noise.
  task automatic run_frame();
    int unsigned pick, len, n;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    select_pin(1'b0);
    if (pick < 25) begin
      len = pick_len();
      spi(CMD_WR_N);
      spi(len[7:0]);
      spi(8'($urandom_range(0, 255)));
      n = (len > MAX_LEN) ? MAX_LEN : len;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
      else if ($urandom_range(0, 19) == 0) n = $urandom_range(MAX_LEN + 1, MAX_LEN + 10);
      repeat (n) spi(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) != 0) select_pin(1'b1);
    end else if (pick < 45) begin
      len = pick_len();
      spi(CMD_RD_N);
      spi(len[7:0]);
      spi(8'($urandom_range(0, 255)));
      select_pin(1'b1);
      if (len > MAX_LEN) len = MAX_LEN;
      n = ($urandom_range(0, 19) == 0) ? BUF_DEPTH + 6 : $urandom_range(0, len + 1);
      repeat (n) send_item(OP_I2C, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) spi(8'($urandom_range(0, 255)));
    end else if (pick < 55) begin
      spi(CMD_RD_BUF);
      n = rx_filled();
      if (n == BUF_DEPTH && $urandom_range(0, 3) == 0) n = BUF_DEPTH + 2;
      else if (n != 0) n = $urandom_range(1, (n < 8) ? n : 8);
      repeat (n) spi(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) select_pin(1'b1);
    end else if (pick < 70) begin
      spi($urandom_range(0, 1) ? CMD_WR_REG : CMD_RD_REG);
      if ($urandom_range(0, 3) != 0) spi(8'($urandom_range(0, REG_COUNT - 1)));
      else if ($urandom_range(0, 1) != 0) spi(8'($urandom_range(REG_COUNT, 7)));
      else spi(8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 3)) spi(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) select_pin(1'b1);
    end else if (pick < 80) begin
      case ($urandom_range(0, 4))
        0: c = CMD_CONF;
        1: c = CMD_PWR;
        2: c = CMD_WR_RD;
        3: c = CMD_WR_WR;
        default: c = 8'($urandom_range(0, 255));
      endcase
      spi(c);
      repeat ($urandom_range(0, 5)) spi(8'($urandom_range(0, 255)));
      select_pin(1'b1);
    end else begin
      repeat ($urandom_range(1, 4))
        send_item(s2i_op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver side: ready is redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every accepted result is compared with the oldest awaited one.
  always @(posedge clk_i) begin
    bridge_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d data %h address %h last %b", $time,
                 kind_o, data_byte_o, slave_address_o, last_o);
        fail_count++;
      end else begin
        want = awaited_q.pop_front();
        if (kind_o !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind_o);
          fail_count++;
        end
        if (data_byte_o !== want.data) begin
          $display("%0t: data_byte expected %h actual %h", $time, want.data, data_byte_o);
          fail_count++;
        end
        if (slave_address_o !== want.addr) begin
          $display("%0t: slave_address expected %h actual %h", $time, want.addr,
                   slave_address_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clear_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].sb, dir_rows[i].lvl, dir_rows[i].ib,
                dir_rows[i].typed, dir_rows[i].data);
    wait_drained();

    // Three random phases with different idling on each side.
    item_count = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 26 : 0;
      while (item_count < (ph + 1) * 75) run_frame();
      wait_drained();
    end

    // Allow for any stray output after the last awaited result.
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> spi_to_i2c_bridge_top.f
sv/s2i_pkg.sv
sv/s2i_ram.sv
sv/s2i_ctrl.sv
sv/s2i_dp.sv
sv/spi_to_i2c_bridge_top.sv
tb/tb_spi_to_i2c_bridge_top.sv
